### sv/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; all other files of the block but pli_checker use this package.
`timescale 1ns / 1ps

package pli_pkg;

   localparam int DATA_W = 32;

   // Request mode codes as they arrive on the input channel.
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_ORDER = 2'd3;

   // Response clamp codes.
   localparam logic [1:0] CL_INTERIOR = 2'd0;
   localparam logic [1:0] CL_LOW      = 2'd1;
   localparam logic [1:0] CL_HIGH     = 2'd2;

   // Command queue between the front and back parts; depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // The divider retires one quotient bit per cycle.
   localparam int DIV_STEPS = DATA_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_LOAD,
      OP_QUERY,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
   } cmd_type;

endpackage

### sv/pli_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on pli_pkg for the data width.
`timescale 1ns / 1ps

interface pli_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       mode;
   logic signed [pli_pkg::DATA_W-1:0] x_value;
   logic signed [pli_pkg::DATA_W-1:0] y_value;

   modport source (output valid, output mode, output x_value, output y_value, input ready);
   modport sink   (input valid, input mode, input x_value, input y_value, output ready);
endinterface

interface pli_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [pli_pkg::DATA_W-1:0] y_out;
   logic [1:0]                       status;
   logic [1:0]                       clamped;

   modport source (output valid, output y_out, output status, output clamped, input ready);
   modport sink   (input valid, input y_out, input status, input clamped, output ready);
endinterface

### sv/pli_front.sv
// Front part: accepts request words, decodes the mode and queues commands.
// Depends on pli_pkg and the request interface in pli_if.sv.
`timescale 1ns / 1ps

module pli_front (
   input  logic            clock,
   input  logic            reset,
   pli_req_if.sink         req,
   output pli_pkg::cmd_type cmd,
   output logic            cmd_valid,
   input  logic            cmd_pop
);
   import pli_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;
   cmd_type             word_in;

   assign req.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign pop       = cmd_pop && (count_ff != '0);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      word_in.x = req.x_value;
      word_in.y = req.y_value;
      unique case (req.mode)
         MODE_CLEAR: word_in.op = OP_CLEAR;
         MODE_LOAD:  word_in.op = OP_LOAD;
         MODE_QUERY: word_in.op = OP_QUERY;
         default:    word_in.op = OP_IGNORE;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

### sv/pli_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// in DATA_W bits (upper half of the dividend below the divisor). Uses pli_pkg.
`timescale 1ns / 1ps

module pli_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2*pli_pkg::DATA_W-1:0]  num,
   input  logic [pli_pkg::DATA_W-1:0]    den,
   output logic                          done,
   output logic [pli_pkg::DATA_W-1:0]    quot
);
   import pli_pkg::*;

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   assign trial = {rem_ff, low_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign done  = done_ff;
   assign quot  = low_ff;

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[2*DATA_W-1:DATA_W];
         low_in  = num[DATA_W-1:0];
         den_in  = den;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits DATA_W bits.
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            low_in = {low_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            low_in = {low_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

endmodule

### sv/pli_back.sv
// Back part: breakpoint table, segment search, interpolation and the
// response register. Depends on pli_pkg, pli_if.sv and pli_div.
`timescale 1ns / 1ps

module pli_back #(
   parameter int MAX_POINTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  pli_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   pli_rsp_if.source        rsp
);
   import pli_pkg::*;

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_LEFT,
      S_RIGHT,
      S_MUL,
      S_DIVGO,
      S_DIV,
      S_FINISH
   } state_type;

   // Breakpoint table.
   logic signed [DATA_W-1:0] mem_x [MAX_POINTS];
   logic signed [DATA_W-1:0] mem_y [MAX_POINTS];
   logic signed [DATA_W-1:0] rd_x_ff;
   logic signed [DATA_W-1:0] rd_y_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         last_idx;
   logic signed [DATA_W-1:0] first_x_ff, first_x_in;
   logic signed [DATA_W-1:0] first_y_ff, first_y_in;
   logic signed [DATA_W-1:0] last_x_ff, last_x_in;
   logic signed [DATA_W-1:0] last_y_ff, last_y_in;
   logic signed [DATA_W-1:0] qx_ff, qx_in;
   logic [ADDR_W-1:0]        lo_ff, lo_in;
   logic [ADDR_W-1:0]        hi_ff, hi_in;
   logic [ADDR_W-1:0]        mid;
   logic signed [DATA_W-1:0] x1_ff, x1_in;
   logic signed [DATA_W-1:0] y1_ff, y1_in;
   logic [DATA_W-1:0]        a_ff, a_in;
   logic [DATA_W-1:0]        b_ff, b_in;
   logic [DATA_W-1:0]        d_ff, d_in;
   logic                     neg_ff, neg_in;
   logic [2*DATA_W-1:0]      prod_ff, prod_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W:0]          diff_a;
   logic [DATA_W:0]          diff_d;
   logic [DATA_W:0]          diff_y;
   logic [DATA_W:0]          mag_y;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] y_out_ff, y_out_in;
   logic [1:0]               status_ff, status_in;
   logic [1:0]               clamped_ff, clamped_in;
   logic                     out_free;

   logic                     div_start;
   logic                     div_done;
   logic [DATA_W-1:0]        div_quot;

   pli_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (d_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.y_out   = y_out_ff;
   assign rsp.status  = status_ff;
   assign rsp.clamped = clamped_ff;
   assign cmd_pop     = (state_ff == S_IDLE) && cmd_valid && out_free;
   assign last_idx    = count_ff - CNT_W'(1);
   assign wr_addr     = count_ff[ADDR_W-1:0];
   assign mid         = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Segment differences; all three fit DATA_W bits as magnitudes.
   assign diff_a = {qx_ff[DATA_W-1], qx_ff} - {x1_ff[DATA_W-1], x1_ff};
   assign diff_d = {rd_x_ff[DATA_W-1], rd_x_ff} - {x1_ff[DATA_W-1], x1_ff};
   assign diff_y = {rd_y_ff[DATA_W-1], rd_y_ff} - {y1_ff[DATA_W-1], y1_ff};
   assign mag_y  = diff_y[DATA_W] ? (~diff_y + (DATA_W + 1)'(1)) : diff_y;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      qx_in        = qx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      y_out_in     = y_out_ff;
      status_in    = status_ff;
      clamped_in   = clamped_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               rsp_valid_in = 1'b1;
               y_out_in     = '0;
               status_in    = ST_OK;
               clamped_in   = CL_INTERIOR;
               unique case (cmd.op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_LOAD: begin
                     // A full table is reported before the order check.
                     if (count_ff == CNT_W'(MAX_POINTS)) begin
                        status_in = ST_FULL;
                     end else if (count_ff != '0 && cmd.x <= last_x_ff) begin
                        status_in = ST_ORDER;
                     end else begin
                        wr_en     = 1'b1;
                        last_x_in = cmd.x;
                        last_y_in = cmd.y;
                        if (count_ff == '0) begin
                           first_x_in = cmd.x;
                           first_y_in = cmd.y;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (cmd.x <= first_x_ff) begin
                        y_out_in   = first_y_ff;
                        clamped_in = CL_LOW;
                     end else if (cmd.x >= last_x_ff) begin
                        y_out_in   = last_y_ff;
                        clamped_in = CL_HIGH;
                     end else begin
                        // Interior: at least two points, the answer comes later.
                        rsp_valid_in = 1'b0;
                        qx_in        = cmd.x;
                        lo_in        = ADDR_W'(1);
                        hi_in        = last_idx[ADDR_W-1:0];
                        state_in     = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid;
               state_in = S_COMPARE;
            end else begin
               rd_addr  = lo_ff - ADDR_W'(1);
               state_in = S_LEFT;
            end
         end
         S_COMPARE: begin
            if (rd_x_ff > qx_ff) begin
               hi_in = mid;
            end else begin
               lo_in = mid + ADDR_W'(1);
            end
            state_in = S_SEARCH;
         end
         S_LEFT: begin
            x1_in    = rd_x_ff;
            y1_in    = rd_y_ff;
            rd_addr  = lo_ff;
            state_in = S_RIGHT;
         end
         S_RIGHT: begin
            a_in     = diff_a[DATA_W-1:0];
            d_in     = diff_d[DATA_W-1:0];
            b_in     = mag_y[DATA_W-1:0];
            neg_in   = diff_y[DATA_W];
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = a_ff * b_ff;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = neg_ff ? (y1_ff - div_quot) : (y1_ff + div_quot);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               y_out_in     = res_ff;
               status_in    = ST_OK;
               clamped_in   = CL_INTERIOR;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      last_x_ff  <= last_x_in;
      last_y_ff  <= last_y_in;
      qx_ff      <= qx_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      d_ff       <= d_in;
      neg_ff     <= neg_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      y_out_ff   <= y_out_in;
      status_ff  <= status_in;
      clamped_ff <= clamped_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= cmd.x;
         mem_y[wr_addr] <= cmd.y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

endmodule

### sv/piecewise_linear_interpolator.sv
// Piecewise linear interpolator. A clear word empties the breakpoint table,
// load words append (x, y) pairs in strictly ascending x, and query words
// return y interpolated at x in signed Q16.16, truncated toward zero, with a
// clamp code when x lies at or beyond either end of the table. Every word
// gets exactly one response word, in order. Request words land in a two-entry
// command queue, so the input keeps accepting while a response waits. The back
// part runs one command at a time: clear, load, ignored modes, empty-table
// queries and clamped queries are answered directly from the idle state. An
// interior query runs a binary search, each step of which waits on a
// registered table read, then reads both segment ends, does one multiply and
// starts a divider that retires one quotient bit per cycle. The table needs
// no clearing pass after reset; of the table state, only the point count is
// reset.
// Depends on pli_pkg, pli_if.sv, pli_front, pli_back and pli_div.
`timescale 1ns / 1ps

module piecewise_linear_interpolator #(
   parameter int MAX_POINTS = 1024
) (
   input  logic      clock,
   input  logic      reset,
   pli_req_if.sink   req_ch,
   pli_rsp_if.source rsp_ch
);
   import pli_pkg::*;

   // Decoded commands travel from the front queue to the back part.
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // The front part takes request words and decodes the mode field.
   pli_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // The back part owns the table, searches, interpolates and drives the
   // response register.
   pli_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_ch)
   );

endmodule

### sv/pli_checker.sv
// Port-level checks for the piecewise linear interpolator and the bind that
// attaches them to the top level. Depends on piecewise_linear_interpolator.
`timescale 1ns / 1ps

module pli_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_y_out,
   input logic [1:0]  rsp_status,
   input logic [1:0]  rsp_clamped
);

   // Words accepted on the request side that have not yet been answered.
   logic [3:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pending_ff <= pending_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         pending_ff <= pending_ff - 4'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_y_out) && $stable(rsp_status) && $stable(rsp_clamped))
      else $error("response word changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response word without an accepted request word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_y_out   (rsp_ch.y_out),
   .rsp_status  (rsp_ch.status),
   .rsp_clamped (rsp_ch.clamped)
);

### sim/testbench.sv
// Self-checking testbench for the piecewise linear interpolator.
// Depends on pli_pkg, the channel interfaces in pli_if.sv and the block itself.
`timescale 1ns / 1ps

module testbench;
   import pli_pkg::*;

   // Table depth of the instance under test. The full-table test fills it completely.
   localparam int TABLE_DEPTH = 1024;

   // The fourth mode code has no meaning. The block answers it and changes nothing.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam longint X_MIN = -64'sd2147483648;
   localparam longint X_MAX = 64'sd2147483647;

   // The limit lies far above what an interior query on a full table takes, even
   // with the idle bursts of the sender and the receiver added.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;

   typedef struct packed {
      logic signed [DATA_W-1:0] y_out;
      logic [1:0]               status;
      logic [1:0]               clamped;
   } rsp_word_type;

   logic clock;
   logic reset;

   pli_req_if req_bus ();
   pli_rsp_if rsp_bus ();

   piecewise_linear_interpolator #(
      .MAX_POINTS(TABLE_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // This is the testbench's own copy of the breakpoint table. It is updated when each
   // request word is accepted.
   logic signed [DATA_W-1:0] pt_x [TABLE_DEPTH];
   logic signed [DATA_W-1:0] pt_y [TABLE_DEPTH];
   int unsigned              pt_count;

   // This queue holds the responses that are predicted but have not yet arrived, oldest first.
   rsp_word_type awaiting_rsp [$];
   rsp_word_type expected_word;

   int  fail_count;
   int  words_sent;
   int  idle_cycles;
   int  stall_left;
   bit  send_gaps_on;
   bit  stall_on;

   int  n_loads;
   int  n_interior;
   int  n_clamped;
   int  n_rejected;

   always #6 clock = ~clock;

   // This function predicts the response to one request word and updates the table copy.
   // A query finds its segment by an upper-bound search: the first breakpoint whose x
   // is above the query x. The offset |dy| * (x - x1) / (x2 - x1) is formed without
   // sign in 64 bits. Then the sign of dy is applied, so the result truncates toward zero.
   function automatic rsp_word_type interpolate_word(input logic [1:0] mode,
                                                     input logic signed [DATA_W-1:0] xv,
                                                     input logic signed [DATA_W-1:0] yv);
      rsp_word_type w;
      int unsigned  lo, hi, mid, top;
      longint       x1, x2, y1, y2, dy, res;
      logic [63:0]  a, b, d, q;
      w = '0;
      case (mode)
         MODE_CLEAR: pt_count = 0;
         MODE_LOAD: begin
            if (pt_count >= TABLE_DEPTH) begin
               w.status = ST_FULL;
               n_rejected++;
            end else if (pt_count > 0 && xv <= pt_x[pt_count-1]) begin
               w.status = ST_ORDER;
               n_rejected++;
            end else begin
               pt_x[pt_count] = xv;
               pt_y[pt_count] = yv;
               pt_count++;
               n_loads++;
            end
         end
         MODE_QUERY: begin
            top = pt_count - 1;
            if (pt_count == 0) begin
               w.status = ST_EMPTY;
               n_rejected++;
            end else if (xv <= pt_x[0]) begin
               w.y_out   = pt_y[0];
               w.clamped = CL_LOW;
               n_clamped++;
            end else if (xv >= pt_x[top]) begin
               w.y_out   = pt_y[top];
               w.clamped = CL_HIGH;
               n_clamped++;
            end else begin
               lo = 1;
               hi = top;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (pt_x[mid] > xv) hi = mid;
                  else lo = mid + 1;
               end
               x1 = pt_x[lo-1];
               x2 = pt_x[lo];
               y1 = pt_y[lo-1];
               y2 = pt_y[lo];
               dy = y2 - y1;
               a = 64'(longint'(xv) - x1);
               d = 64'(x2 - x1);
               b = (dy < 0) ? 64'(-dy) : 64'(dy);
               q = (a * b) / d;
               res = (dy < 0) ? y1 - longint'(q) : y1 + longint'(q);
               w.y_out = res[DATA_W-1:0];
               n_interior++;
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   // This task sends one request word. It may idle for a short burst first. It returns
   // at the clock edge where the word was accepted, with valid still high. The next call,
   // or the final clean-up, decides what valid does next.
   task automatic send_word(input logic [1:0] mode,
                            input logic signed [DATA_W-1:0] xv,
                            input logic signed [DATA_W-1:0] yv);
      int gap;
      begin
         if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.valid   <= 1'b1;
         req_bus.mode    <= mode;
         req_bus.x_value <= xv;
         req_bus.y_value <= yv;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         awaiting_rsp.push_back(interpolate_word(mode, xv, yv));
         if (mode != MODE_UNUSED) words_sent++;
      end
   endtask

   // This task sends a query. Half of the queries fall inside the loaded span. The rest land
   // exactly on a breakpoint, one step beside one, or anywhere in the 32-bit range.
   task automatic random_query;
      int                       kind;
      int unsigned              idx;
      longint                   lo_x, hi_x, xv;
      logic signed [DATA_W-1:0] r;
      begin
         kind = $urandom_range(0, 9);
         r = $urandom();
         xv = r;
         if (pt_count > 0) begin
            lo_x = pt_x[0];
            hi_x = pt_x[pt_count-1];
            idx = $urandom_range(0, pt_count - 1);
            if (kind < 5) xv = lo_x + longint'($urandom_range(0, 32'(hi_x - lo_x)));
            else if (kind < 7) xv = pt_x[idx];
            else if (kind == 7) xv = longint'(pt_x[idx]) + ($urandom_range(0, 1) ? 1 : -1);
         end
         send_word(MODE_QUERY, 32'(xv), $urandom());
      end
   endtask

   // This task appends a run of ascending breakpoints. The spacing ranges from a few LSBs
   // to a quarter of the range. Sometimes a load is sent whose x does not rise, and the
   // block must reject it.
   task automatic load_run(input int points);
      longint                   span, xv;
      int                       i;
      logic signed [DATA_W-1:0] r;
      begin
         case ($urandom_range(0, 4))
            0: span = 3;
            1: span = 255;
            2: span = 65535;
            3: span = 64'd1 << 24;
            default: span = 64'd1 << 30;
         endcase
         if (span >= (64'd1 << 24)) begin
            xv = X_MIN + longint'($urandom_range(0, 1 << 20));
         end else begin
            r = $urandom();
            xv = r;
         end
         if (pt_count > 0 && xv <= pt_x[pt_count-1]) xv = longint'(pt_x[pt_count-1]) + 1;
         for (i = 0; i < points && xv <= X_MAX; i++) begin
            if (pt_count > 0 && $urandom_range(0, 9) == 0)
               send_word(MODE_LOAD, 32'(longint'(pt_x[pt_count-1]) - $urandom_range(0, 2)),
                         $urandom());
            send_word(MODE_LOAD, 32'(xv), $urandom());
            xv = xv + longint'($urandom_range(1, 32'(span)));
         end
      end
   endtask

   task automatic test_empty_table;
      begin
         send_word(MODE_QUERY, 32'sd0, 32'sd0);
         send_word(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         send_word(MODE_CLEAR, 32'h8000_0000, 32'h7FFF_FFFF);
      end
   endtask

   // With a single breakpoint, every query returns its y. Only the clamp code shows
   // which side of the breakpoint the query x is on.
   task automatic test_single_point;
      begin
         send_word(MODE_LOAD, 32'sh0001_0000, 32'sh1234_5678);
         send_word(MODE_QUERY, 32'sh0000_FFFF, 32'sd0);
         send_word(MODE_QUERY, 32'sh0001_0000, 32'sd0);
         send_word(MODE_QUERY, 32'sh0001_0001, 32'sd0);
         send_word(MODE_LOAD, 32'sh0001_0000, 32'sd5);
      end
   endtask

   // These are the corners of the 32-bit range. A query in the middle of a full-range
   // segment needs the whole 64-bit product.
   task automatic test_extremes;
      begin
         send_word(MODE_CLEAR, 32'sd0, 32'sd0);
         send_word(MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
         send_word(MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
         send_word(MODE_QUERY, 32'sd0, 32'sd0);
         send_word(MODE_QUERY, 32'h8000_0000, 32'sd0);
         send_word(MODE_QUERY, 32'h7FFF_FFFF, 32'sd0);
         send_word(MODE_QUERY, 32'h7FFF_FFFE, 32'sd0);
         send_word(MODE_QUERY, 32'h8000_0001, 32'sd0);
         send_word(MODE_LOAD, 32'h0000_0000, 32'sd0);
      end
   endtask

   // Small slopes of both signs show that the offset truncates toward zero.
   task automatic test_truncation;
      begin
         send_word(MODE_CLEAR, 32'sd0, 32'sd0);
         send_word(MODE_LOAD, 32'sd0, 32'sd0);
         send_word(MODE_LOAD, 32'sd3, 32'sd10);
         send_word(MODE_LOAD, 32'sd6, 32'sd0);
         send_word(MODE_QUERY, 32'sd1, 32'sd0);
         send_word(MODE_QUERY, 32'sd4, 32'sd0);
         send_word(MODE_QUERY, 32'sd5, 32'sd0);
      end
   endtask

   // This test fills every entry of the table. It then sends loads into the full table;
   // the full status takes precedence over the order check. It then queries across all
   // 1024 points, which is the deepest binary search.
   task automatic test_full_table;
      int     i;
      longint xv;
      begin
         send_word(MODE_CLEAR, 32'sd0, 32'sd0);
         for (i = 0; i < TABLE_DEPTH; i++) begin
            xv = X_MIN + longint'(i) * 64'd4194304 + longint'($urandom_range(0, 4194303));
            send_word(MODE_LOAD, 32'(xv), $urandom());
         end
         send_word(MODE_LOAD, 32'h7FFF_FFFF, 32'sd1);
         send_word(MODE_LOAD, 32'h8000_0000, 32'sd1);
         for (i = 0; i < 40; i++) random_query();
         send_word(MODE_CLEAR, 32'sd0, 32'sd0);
      end
   endtask

   // Most of the traffic is well-formed: a clear, a run of loads, then queries, and
   // sometimes more loads and queries on the same table. The rest is noise of random
   // words in every mode.
   task automatic test_random_sequences(input int quota, input bit allow_idle);
      int target, i, n, points;
      begin
         target = words_sent + quota;
         while (words_sent < target) begin
            send_gaps_on = allow_idle && ($urandom_range(0, 3) != 0);
            stall_on     = allow_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8) begin
               send_word(MODE_CLEAR, $urandom(), $urandom());
               if ($urandom_range(0, 5) == 0) random_query();
               case ($urandom_range(0, 4))
                  0:       points = $urandom_range(1, 3);
                  4:       points = $urandom_range(17, 64);
                  default: points = $urandom_range(4, 16);
               endcase
               load_run(points);
               n = $urandom_range(2, 12);
               for (i = 0; i < n; i++) random_query();
               if ($urandom_range(0, 3) == 0) begin
                  load_run($urandom_range(1, 6));
                  n = $urandom_range(1, 6);
                  for (i = 0; i < n; i++) random_query();
               end
            end else begin
               n = $urandom_range(1, 5);
               for (i = 0; i < n; i++)
                  send_word(2'($urandom_range(0, 3)), $urandom(), $urandom());
            end
         end
      end
   endtask

   // The receiver stalls in random bursts while stall_on is set. Otherwise it is always ready.
   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_bus.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Each accepted response word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaiting_rsp.size() == 0) begin
            $error("response word arrived with no request outstanding");
            fail_count++;
         end else begin
            expected_word = awaiting_rsp.pop_front();
            if (rsp_bus.y_out !== expected_word.y_out) begin
               $error("y_out: expected %0d, got %0d", expected_word.y_out, rsp_bus.y_out);
               fail_count++;
            end
            if (rsp_bus.status !== expected_word.status) begin
               $error("status: expected %0d, got %0d", expected_word.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.clamped !== expected_word.clamped) begin
               $error("clamped: expected %0d, got %0d", expected_word.clamped,
                      rsp_bus.clamped);
               fail_count++;
            end
         end
      end
   end

   // The watchdog ends the run when neither channel has accepted a word for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[piecewise_linear_interpolator] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_CLEAR;
      req_bus.x_value = '0;
      req_bus.y_value = '0;
      rsp_bus.ready   = 1'b0;
      pt_count        = 0;
      fail_count      = 0;
      words_sent      = 0;
      idle_cycles     = 0;
      stall_left      = 0;
      n_loads         = 0;
      n_interior      = 0;
      n_clamped       = 0;
      n_rejected      = 0;
      send_gaps_on    = 1'b1;
      stall_on        = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_single_point();
      test_extremes();
      test_truncation();
      test_full_table();
      test_random_sequences(300, 1'b1);
      // The final stretch runs at full rate on both sides.
      test_random_sequences(130, 1'b0);

      req_bus.valid <= 1'b0;
      while (awaiting_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words: %0d breakpoints stored, %0d interior queries,",
               words_sent, n_loads, n_interior);
      $display("%0d clamped queries and %0d rejected words; %0d mismatches.",
               n_clamped, n_rejected, fail_count);
      if (fail_count == 0 && awaiting_rsp.size() == 0) begin
         $display("[piecewise_linear_interpolator] OK");
      end else begin
         $display("[piecewise_linear_interpolator] ERROR");
      end
      $finish;
   end

endmodule
